// File: design/kmcd_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// kmcd_pkg
// Shared types and constants of the key matrix change detector: the scan and
// change payloads and the load word passed to the bit-serial event stage.
// ============================================================================
package kmcd_pkg;

    // Fixed field widths
    localparam int ROW_W   = 3;
    localparam int COL_W   = 8;
    localparam int KEY_W   = 6;

    // One scanned row
    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] column_bits;
    } scan_item_t;

    // One key change event
    typedef struct packed {
        logic [KEY_W-1:0] key_id;
        logic             pressed;
        logic             last;
    } change_item_t;

    // Work handed to the serializer for one row
    typedef struct packed {
        logic [COL_W-1:0] diff;
        logic [COL_W-1:0] fresh;
        logic [KEY_W-1:0] base;
    } load_t;

endpackage

// File: design/key_matrix_change_detector_top.sv
`timescale 1ns / 1ps
// ============================================================================
// key_matrix_change_detector_top
// Key matrix change detector: keeps the level of every key and emits one
// event per key whose level changed in a newly scanned row.
// ============================================================================
// Each scan transfer carries one row number and its column levels. The row
// word is compared with the stored levels in the transfer cycle and stored at
// once; the changed columns then leave a shift register one column per
// cycle, lowest column first, except while a changed column waits for a
// stalled output register; each set bit gives one change event, with the
// last event of the row marked. The next row is taken as soon as the shift
// register is empty, while the final event may still wait in the output
// register. An unchanged row, or a row number at or above ROWS, gives no
// event. Column bits at or above COLUMNS are ignored. All keys read as
// released after reset.
// ============================================================================
module key_matrix_change_detector_top
#(
    parameter int ROWS    = 8,
    parameter int COLUMNS = 8
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   scan_valid,
    output logic                   scan_stall,
    input  kmcd_pkg::scan_item_t   scan,
    output logic                   change_valid,
    input  logic                   change_stall,
    output kmcd_pkg::change_item_t change
);
    import kmcd_pkg::*;

    localparam int               SCAN_COLS  = (COLUMNS < COL_W) ? COLUMNS : COL_W;
    localparam int               STORE_ROWS = (ROWS < (1 << ROW_W)) ? ROWS : (1 << ROW_W);
    localparam int               RIDX_W     = (STORE_ROWS > 1) ? $clog2(STORE_ROWS) : 1;
    localparam logic [COL_W-1:0] COL_MASK   = COL_W'((1 << SCAN_COLS) - 1);
    localparam logic [4:0]       ROWS_W     = 5'(ROWS);

    logic [COL_W-1:0] levels_reg [STORE_ROWS];

    logic             busy;
    logic             accept;
    logic             row_ok;
    logic [RIDX_W-1:0] ridx;
    logic [COL_W-1:0] fresh;
    load_t            load;

    assign scan_stall = busy;
    assign accept     = scan_valid && !busy;
    assign row_ok     = ({2'b00, scan.row} < ROWS_W);
    assign ridx       = scan.row[RIDX_W-1:0];
    assign fresh      = scan.column_bits & COL_MASK;

    // Compare against the stored row word
    always_comb
    begin
        load.fresh = fresh;
        load.base  = KEY_W'(scan.row * COLUMNS);
        load.diff  = '0;
        if (row_ok)
        begin
            load.diff = fresh ^ levels_reg[ridx];
        end
    end

    // Key level store, one word per row
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < STORE_ROWS; i++)
            begin
                levels_reg[i] <= '0;
            end
        end
        else if (accept && row_ok)
        begin
            levels_reg[ridx] <= fresh;
        end
    end

    kmcd_serial u_serial
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .load_valid   (accept),
        .load         (load),
        .busy         (busy),
        .change_valid (change_valid),
        .change_stall (change_stall),
        .change       (change)
    );

endmodule

// File: design/kmcd_serial.sv
`timescale 1ns / 1ps
// ============================================================================
// kmcd_serial
// Bit-serial event stage: shifts the changed-column mask and the new levels
// out one column per cycle, pausing on a set bit while the output register
// is held full; each set bit places one change event in the output register.
// ============================================================================
module kmcd_serial
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   load_valid,
    input  kmcd_pkg::load_t        load,
    output logic                   busy,
    output logic                   change_valid,
    input  logic                   change_stall,
    output kmcd_pkg::change_item_t change
);
    import kmcd_pkg::*;

    logic [COL_W-1:0] diff_reg,  diff_next;
    logic [COL_W-1:0] fresh_reg, fresh_next;
    logic [KEY_W-1:0] key_reg,   key_next;
    logic             out_valid_reg, out_valid_next;
    change_item_t     out_reg,   out_next;

    logic slot_free;
    logic emit;
    logic advance;

    // Output slot is free when empty or being taken this cycle
    assign slot_free = !out_valid_reg || !change_stall;
    assign busy      = (diff_reg != '0);
    assign emit      = busy && diff_reg[0] && slot_free;
    assign advance   = busy && (!diff_reg[0] || slot_free);

    // Shift one column per cycle, stall on a set bit while the slot is full
    always_comb
    begin
        diff_next      = diff_reg;
        fresh_next     = fresh_reg;
        key_next       = key_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (slot_free)
        begin
            out_valid_next = 1'b0;
        end
        if (load_valid)
        begin
            diff_next  = load.diff;
            fresh_next = load.fresh;
            key_next   = load.base;
        end
        else if (advance)
        begin
            diff_next  = diff_reg >> 1;
            fresh_next = fresh_reg >> 1;
            key_next   = key_reg + KEY_W'(1);
        end
        if (emit)
        begin
            out_valid_next   = 1'b1;
            out_next.key_id  = key_reg;
            out_next.pressed = fresh_reg[0];
            out_next.last    = (diff_reg[COL_W-1:1] == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            diff_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            diff_reg      <= diff_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fresh_reg <= fresh_next;
        key_reg   <= key_next;
        out_reg   <= out_next;
    end

    assign change_valid = out_valid_reg;
    assign change       = out_reg;

    // A new row is only loaded once the previous one has drained
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        load_valid |-> !busy)
        else $error("row loaded while serializer busy");

    // An unchanged row leaves the serializer idle
    a_empty_load: assert property (@(posedge clk) disable iff (!rst_n)
        load_valid && (load.diff == '0) |=> !busy)
        else $error("empty row made serializer busy");

    // A clear column never waits for the output slot
    a_skip_zero: assert property (@(posedge clk) disable iff (!rst_n)
        busy && !diff_reg[0] && !load_valid |=> diff_reg == ($past(diff_reg) >> 1))
        else $error("clear column did not advance");

    // The event marked last is the one emitted with no changes left above
    a_last_drain: assert property (@(posedge clk) disable iff (!rst_n)
        emit && (diff_reg[COL_W-1:1] == '0) |=> !busy && out_reg.last)
        else $error("last event does not end the row");

endmodule
